### rtl/victim_cache_swap_assert.svh
// ----------------------------------------------------------------------------
// Victim cache swap assertion macros
// Concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef VICTIM_CACHE_SWAP_ASSERT_SVH
`define VICTIM_CACHE_SWAP_ASSERT_SVH

// same-cycle implication
`define VCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vcs_pkg.sv
// ----------------------------------------------------------------------------
// Victim cache swap package
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcs_pkg;

  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 4;
  localparam int WAYS_W   = 5;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // register index, taken from paddr[2]
  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_WAYS_IN_USE = 1'b1;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd5;
  localparam logic [WAYS_W-1:0]   WAYS_RESET   = 5'd16;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_bits;
    logic [WAYS_W-1:0]   ways_in_use;
  } vcs_cfg_t;

  typedef struct packed {
    logic load;    // capture request tags
    logic look;    // register lookup results
    logic commit;  // update entries, drive result
  } vcs_cmd_t;

endpackage

### rtl/vcs_ctrl.sv
// ----------------------------------------------------------------------------
// Victim cache swap controller
// Three-state sequencer: idle, lookup, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcs_ctrl
  import vcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output vcs_cmd_t cmd,
  output logic     out_valid
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;
  logic       out_valid_r;

  // a new request may enter during commit
  assign accept = start && (state_r != ST_LOOK);
  assign busy   = (state_r == ST_LOOK);

  always_comb begin
    case (state_r)
      ST_IDLE, ST_COMMIT: begin
        state_nxt = accept ? ST_LOOK : ST_IDLE;
      end
      ST_LOOK: begin
        state_nxt = ST_COMMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_COMMIT);
    end
  end

  assign cmd.load   = accept;
  assign cmd.look   = (state_r == ST_LOOK);
  assign cmd.commit = (state_r == ST_COMMIT);
  assign out_valid  = out_valid_r;

endmodule

### rtl/vcs_datapath.sv
// ----------------------------------------------------------------------------
// Victim cache swap datapath
// Entry array, tag match, free-slot search, LRU rank tree and rank update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcs_datapath
  import vcs_pkg::*;
#(
  parameter int MAX_WAYS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vcs_cmd_t          cmd,
  input  vcs_cfg_t          cfg,
  input  logic [ADDR_W-1:0] in_block_address,
  input  logic [ADDR_W-1:0] in_victim_address,
  input  logic              in_victim_dirty,
  output logic              out_swap_hit,
  output logic              out_hit_dirty,
  output logic              out_writeback_valid,
  output logic [ADDR_W-1:0] out_writeback_address
);

  localparam int IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = $clog2(MAX_WAYS + 1);
  localparam int LEAVES = 2 ** IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  // request
  logic [ADDR_W-1:0] req_tag_r, vic_tag_r;
  logic              victim_dirty_r;

  // entries
  logic [MAX_WAYS-1:0] valid_r, dirty_r;
  logic [ADDR_W-1:0]   tag_r   [MAX_WAYS];
  logic [RANK_W-1:0]   rank_r  [MAX_WAYS];
  logic [RANK_W-1:0]   rank_nxt[MAX_WAYS];

  logic [MAX_WAYS-1:0] in_use, match, empty;
  logic                hit_found, free_found;
  logic [IDX_W-1:0]    hit_idx, free_idx, lru_idx, slot;

  logic [RANK_W-1:0]   node_rank[NODES];
  logic [IDX_W-1:0]    node_idx [NODES];

  // lookup results
  logic                hit_r, hit_dirty_r, wb_valid_r;
  logic [IDX_W-1:0]    slot_r;
  logic [RANK_W-1:0]   old_rank_r;
  logic [ADDR_W-1:0]   wb_addr_r;

  // result
  logic                res_hit_r, res_dirty_r, res_wb_r;
  logic [ADDR_W-1:0]   res_addr_r;

  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
    // a count of zero still uses way 0
    assign in_use[g] = (g == 0) || (32'(g) < 32'(cfg.ways_in_use));
    assign match[g]  = in_use[g] && valid_r[g] && (tag_r[g] == req_tag_r);
    assign empty[g]  = in_use[g] && !valid_r[g];
  end

  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (empty[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // max-rank tree; ties go left, so the lowest index wins
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < MAX_WAYS) begin : g_real
      assign node_rank[LEAVES-1+g] = in_use[g] ? rank_r[g] : '0;
    end else begin : g_pad
      assign node_rank[LEAVES-1+g] = '0;
    end
    assign node_idx[LEAVES-1+g] = IDX_W'(g);
  end

  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    logic pick_right;
    assign pick_right   = node_rank[2*k+2] > node_rank[2*k+1];
    assign node_rank[k] = pick_right ? node_rank[2*k+2] : node_rank[2*k+1];
    assign node_idx[k]  = pick_right ? node_idx[2*k+2]  : node_idx[2*k+1];
  end

  assign lru_idx = node_idx[0];
  assign slot    = hit_found ? hit_idx : (free_found ? free_idx : lru_idx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_tag_r      <= in_block_address >> cfg.offset_bits;
      vic_tag_r      <= in_victim_address >> cfg.offset_bits;
      victim_dirty_r <= in_victim_dirty;
    end
    if (cmd.look) begin
      hit_r       <= hit_found;
      hit_dirty_r <= hit_found && dirty_r[hit_idx];
      slot_r      <= slot;
      old_rank_r  <= rank_r[slot];
      wb_valid_r  <= !hit_found && !free_found && dirty_r[lru_idx];
      wb_addr_r   <= (!hit_found && !free_found && dirty_r[lru_idx]) ?
                     (tag_r[lru_idx] << cfg.offset_bits) : '0;
    end
    if (cmd.commit) begin
      res_hit_r  <= hit_r;
      res_dirty_r <= hit_dirty_r;
      res_wb_r   <= wb_valid_r;
      res_addr_r <= wb_addr_r;
    end
  end

  // rank counting: a fresh entry ages every ranked one by one, a re-used one only the more recent ones
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      rank_nxt[j] = rank_r[j];
      if (IDX_W'(j) == slot_r) begin
        rank_nxt[j] = RANK_W'(1);
      end else if (in_use[j] && (rank_r[j] != '0) &&
                   ((old_rank_r == '0) || (rank_r[j] < old_rank_r)) &&
                   (rank_r[j] < RANK_W'(MAX_WAYS))) begin
        rank_nxt[j] = rank_r[j] + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      for (int j = 0; j < MAX_WAYS; j++) begin
        rank_r[j] <= '0;
      end
    end else if (cmd.commit) begin
      valid_r[slot_r] <= 1'b1;
      dirty_r[slot_r] <= victim_dirty_r;
      for (int j = 0; j < MAX_WAYS; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tag_r[slot_r] <= vic_tag_r;
    end
  end

  assign out_swap_hit          = res_hit_r;
  assign out_hit_dirty         = res_dirty_r;
  assign out_writeback_valid   = res_wb_r;
  assign out_writeback_address = res_addr_r;

endmodule

### rtl/victim_cache_swap.sv
// ----------------------------------------------------------------------------
// Victim cache swap
// Fully associative victim cache with LRU rank counting; one request per
// main-cache miss, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  request   start / busy            in_block_address, in_victim_address,
//                                    in_victim_dirty
//  result    out_valid (1-cycle)     out_swap_hit, out_hit_dirty,
//                                    out_writeback_valid, out_writeback_address
//  config    APB psel/penable/pready offset_bits @0x0, ways_in_use @0x4
//
//  A transaction is accepted on start && !busy. It passes through a lookup
//  state (tag compare, free-slot search, LRU rank tree) and a commit state
//  (entry write, rank update). busy is high only in the lookup state, so a
//  new request can be taken during the commit of the previous one. The result
//  strobe is registered from the commit state and lasts one cycle; the receiver cannot
//  stall it. Synchronous reset clears valid, dirty and rank state at once,
//  tags are left as they are.
//
`timescale 1ns / 1ps

module victim_cache_swap
  import vcs_pkg::*;
#(
  parameter int MAX_WAYS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  in_block_address,
  input  logic [ADDR_W-1:0]  in_victim_address,
  input  logic               in_victim_dirty,
  // result
  output logic               out_valid,
  output logic               out_swap_hit,
  output logic               out_hit_dirty,
  output logic               out_writeback_valid,
  output logic [ADDR_W-1:0]  out_writeback_address,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [OFFSET_W-1:0] offset_bits_r;
  logic [WAYS_W-1:0]   ways_in_use_r;
  logic                cfg_write;
  vcs_cfg_t            cfg;
  vcs_cmd_t            cmd;

  // Register file: no wait states. Only paddr[2] selects the register,
  // the low address bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_RESET;
      ways_in_use_r <= WAYS_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_OFFSET_BITS: offset_bits_r <= pwdata[OFFSET_W-1:0];
        REG_WAYS_IN_USE: ways_in_use_r <= pwdata[WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OFFSET_BITS: prdata = DATA_W'(offset_bits_r);
      REG_WAYS_IN_USE: prdata = DATA_W'(ways_in_use_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.offset_bits = offset_bits_r;
  assign cfg.ways_in_use = ways_in_use_r;

  // sequencer
  vcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // entries, lookup and LRU
  vcs_datapath #(
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg                   (cfg),
    .in_block_address      (in_block_address),
    .in_victim_address     (in_victim_address),
    .in_victim_dirty       (in_victim_dirty),
    .out_swap_hit          (out_swap_hit),
    .out_hit_dirty         (out_hit_dirty),
    .out_writeback_valid   (out_writeback_valid),
    .out_writeback_address (out_writeback_address)
  );

endmodule

### rtl/vcs_checker.sv
// ----------------------------------------------------------------------------
// Victim cache swap checker
// Port-level timing and result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "victim_cache_swap_assert.svh"

module vcs_checker
  import vcs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              out_swap_hit,
  input logic              out_hit_dirty,
  input logic              out_writeback_valid,
  input logic [ADDR_W-1:0] out_writeback_address
);

  `VCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy, "no lookup after accept")
  `VCS_ASSERT_NEXT(a_busy_one_cycle, clk, rst_n, busy, !busy, "busy longer than one cycle")
  `VCS_ASSERT_NEXT(a_result_latency, clk, rst_n, start && !busy, ##2 out_valid, "result missing")
  `VCS_ASSERT_SAME(a_hit_no_writeback, clk, rst_n, out_valid && out_swap_hit, !out_writeback_valid, "hit with writeback")
  `VCS_ASSERT_SAME(a_clean_miss_fields, clk, rst_n, out_valid && !out_writeback_valid, (out_writeback_address == '0) && (out_swap_hit || !out_hit_dirty), "stale result field")

endmodule

bind victim_cache_swap vcs_checker u_vcs_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// Victim cache swap testbench
// Drives lookup/swap requests through the start/busy port and programs the
// offset and way-count registers over APB. A local LRU victim cache model
// predicts every result, and each result strobe is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import vcs_pkg::*;

  localparam int NUM_WAYS     = 16;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int POOL_DEPTH   = 24;
  localparam int MAX_REPORTS  = 10;

  // register byte addresses, index sits on paddr[2]
  localparam logic [PADDR_W-1:0] ADDR_OFFSET_BITS = {REG_OFFSET_BITS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_WAYS_IN_USE = {REG_WAYS_IN_USE, 2'b00};

  typedef struct packed {
    logic              swap_hit;
    logic              hit_dirty;
    logic              wb_valid;
    logic [ADDR_W-1:0] wb_addr;
  } swap_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n             = 1'b0;
  logic               start             = 1'b0;
  logic               busy;
  logic [ADDR_W-1:0]  in_block_address  = '0;
  logic [ADDR_W-1:0]  in_victim_address = '0;
  logic               in_victim_dirty   = 1'b0;
  logic               out_valid;
  logic               out_swap_hit;
  logic               out_hit_dirty;
  logic               out_writeback_valid;
  logic [ADDR_W-1:0]  out_writeback_address;
  logic               psel              = 1'b0;
  logic               penable           = 1'b0;
  logic               pwrite            = 1'b0;
  logic [PADDR_W-1:0] paddr             = '0;
  logic [DATA_W-1:0]  pwdata            = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  victim_cache_swap #(
    .MAX_WAYS (NUM_WAYS)
  ) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_block_address      (in_block_address),
    .in_victim_address     (in_victim_address),
    .in_victim_dirty       (in_victim_dirty),
    .out_valid             (out_valid),
    .out_swap_hit          (out_swap_hit),
    .out_hit_dirty         (out_hit_dirty),
    .out_writeback_valid   (out_writeback_valid),
    .out_writeback_address (out_writeback_address),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // --------------------------------------------------------------------------
  // Victim cache model: register mirror and per-entry state
  // --------------------------------------------------------------------------
  logic [OFFSET_W-1:0] cfg_offset = OFFSET_RESET;
  logic [WAYS_W-1:0]   cfg_ways   = WAYS_RESET;

  logic                ent_valid [NUM_WAYS];
  logic                ent_dirty [NUM_WAYS];
  logic [ADDR_W-1:0]   ent_tag   [NUM_WAYS];
  logic [WAYS_W-1:0]   ent_rank  [NUM_WAYS];

  swap_result_t        pending_results [$];  // predicted, not yet seen
  logic [ADDR_W-1:0]   recent_victims  [$];  // feeds block addresses that hit

  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;

  initial begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      ent_valid[i] = 1'b0;
      ent_dirty[i] = 1'b0;
      ent_tag[i]   = '0;   // only read once the entry is valid
      ent_rank[i]  = '0;
    end
  end

  // Rank counting: a fresh entry (rank 0) pushes every ranked in-use entry
  // down one step; a re-used entry pushes only the ones that were more recent.
  // Ranks saturate at NUM_WAYS.
  function automatic void promote_entry(input int unsigned e, input int unsigned n);
    logic [WAYS_W-1:0] old_rank;
    logic [WAYS_W-1:0] q;
    old_rank = ent_rank[e];
    for (int unsigned j = 0; j < n; j++) begin
      q = ent_rank[j];
      if (j != e && q != 0 && (old_rank == 0 || q < old_rank) && q < NUM_WAYS)
        ent_rank[j] = q + 1'b1;
    end
    ent_rank[e] = WAYS_W'(1);
  endfunction

  // One request: hit and swap, else fill a free way, else replace the LRU way
  // (writeback when it was dirty).
  function automatic swap_result_t predict_swap(input logic [ADDR_W-1:0] blk_addr,
                                                input logic [ADDR_W-1:0] vic_addr,
                                                input logic              evict_dirty);
    int unsigned       n;
    int unsigned       slot;
    logic [WAYS_W-1:0] best;
    logic [ADDR_W-1:0] req_tag;
    logic [ADDR_W-1:0] vic_tag;
    bit                hit;
    bit                free_found;
    swap_result_t      res;
    // out-of-range way counts clamp to 1..NUM_WAYS
    n = 32'(cfg_ways);
    if (n == 0) n = 1;
    if (n > NUM_WAYS) n = NUM_WAYS;
    req_tag = blk_addr >> cfg_offset;
    vic_tag = vic_addr >> cfg_offset;
    res = '0;
    hit = 1'b0;
    slot = 0;
    // lowest-numbered matching way wins when tags are duplicated
    for (int unsigned i = 0; i < n; i++) begin
      if (!hit && ent_valid[i] && ent_tag[i] == req_tag) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      promote_entry(slot, n);
      res.swap_hit   = 1'b1;
      res.hit_dirty  = ent_dirty[slot];
      ent_tag[slot]   = vic_tag;
      ent_dirty[slot] = evict_dirty;
      return res;
    end
    free_found = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!free_found && !ent_valid[i]) begin
        free_found = 1'b1;
        slot = i;
      end
    end
    if (!free_found) begin
      // LRU is the highest rank, lowest index among equals
      best = '0;
      slot = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (ent_rank[i] > best) begin
          best = ent_rank[i];
          slot = i;
        end
      end
      if (ent_dirty[slot]) begin
        res.wb_valid = 1'b1;
        res.wb_addr  = ent_tag[slot] << cfg_offset;
      end
    end
    ent_valid[slot] = 1'b1;
    promote_entry(slot, n);
    ent_dirty[slot] = evict_dirty;
    ent_tag[slot]   = vic_tag;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit, reporting
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("victim_cache_swap verification failed");
      $finish;
    end
  end

  function automatic void flag_field(input string what, input logic [ADDR_W-1:0] exp_val,
                                     input logic [ADDR_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("MISMATCH %s: expected %h, got %h", what, exp_val, act_val);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: the strobe lasts one cycle and cannot be held off, so the
  // transaction is taken at the edge closing a cycle with out_valid high.
  // Values read here are the pre-edge ones.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    swap_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("MISMATCH unexpected result: hit %b dirty %b wb %b addr %h",
                   out_swap_hit, out_hit_dirty, out_writeback_valid,
                   out_writeback_address);
      end else begin
        exp_res = pending_results.pop_front();
        flag_field("swap_hit", ADDR_W'(exp_res.swap_hit), ADDR_W'(out_swap_hit));
        flag_field("hit_dirty", ADDR_W'(exp_res.hit_dirty), ADDR_W'(out_hit_dirty));
        flag_field("writeback_valid", ADDR_W'(exp_res.wb_valid),
                   ADDR_W'(out_writeback_valid));
        flag_field("writeback_address", exp_res.wb_addr, out_writeback_address);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Called right after a rising edge; start stays high when
  // the next request follows at once, so it is never dropped and re-raised
  // in one time step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [ADDR_W-1:0] blk_addr,
                              input logic [ADDR_W-1:0] vic_addr,
                              input logic              evict_dirty);
    start             <= 1'b1;
    in_block_address  <= blk_addr;
    in_victim_address <= vic_addr;
    in_victim_dirty   <= evict_dirty;
    do @(posedge clk); while (busy);
    // accepted at this edge
    pending_results.push_back(predict_swap(blk_addr, vic_addr, evict_dirty));
    recent_victims.push_back(vic_addr);
    if (recent_victims.size() > POOL_DEPTH) void'(recent_victims.pop_front());
  endtask

  // sender idles with the given chance per cycle
  task automatic idle_cycles(input int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_block_address <= $urandom;   // junk while idle
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // hold off until every predicted result has been checked; the commit of the
  // last transaction is done by its strobe
  task automatic wait_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access until pready, then an idle state so
  // back-to-back calls never drive psel twice in one time step
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, ADDR_OFFSET_BITS, '0, rd);
    flag_field("offset_bits readback", DATA_W'(cfg_offset), rd);
    apb_access(1'b0, ADDR_WAYS_IN_USE, '0, rd);
    flag_field("ways_in_use readback", DATA_W'(cfg_ways), rd);
  endtask

  // waits until idle before writing the registers
  task automatic set_config(input logic [OFFSET_W-1:0] offset,
                            input logic [WAYS_W-1:0]   ways);
    logic [DATA_W-1:0] rd;
    wait_drain();
    apb_access(1'b1, ADDR_OFFSET_BITS, DATA_W'(offset), rd);
    cfg_offset = offset;
    apb_access(1'b1, ADDR_WAYS_IN_USE, DATA_W'(ways), rd);
    cfg_ways = ways;
    check_registers();
  endtask

  // --------------------------------------------------------------------------
  // Address helpers
  // --------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] blk(input logic [ADDR_W-1:0] tag);
    return tag << cfg_offset;
  endfunction

  // mostly a small tag set near either end of the tag range, so ways fill,
  // repeat and evict; a quarter fully random
  function automatic logic [ADDR_W-1:0] make_address();
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] low_mask;
    low_mask = (32'h1 << cfg_offset) - 32'h1;
    if ($urandom_range(0, 99) < 25) return $urandom;
    tag = $urandom_range(0, 47);
    if ($urandom_range(0, 1) != 0) tag = (32'hFFFF_FFFF >> cfg_offset) - tag;
    return (tag << cfg_offset) | ($urandom & low_mask);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_defaults();
    check_registers();
  endtask

  // empty fill, hit on a dirty way, extreme addresses, duplicate tags
  task automatic test_fill_and_hit();
    send_request(blk(1), blk(100), 1'b1);
    send_request(blk(100) | 32'h1F, blk(101), 1'b0);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_request(blk(7), blk(101), 1'b1);     // second copy of tag 101
    send_request(blk(101), blk(102), 1'b0);   // lowest way must hit
  endtask

  // two ways in use: way 2 goes out of reach, then LRU replacement with a
  // clean and a dirty eviction; regrowing brings way 2 back
  task automatic test_replacement();
    set_config(OFFSET_W'(5), WAYS_W'(2));
    send_request(blk(101), blk(60), 1'b1);
    send_request(blk(61), blk(62), 1'b0);
    send_request(blk(63), blk(64), 1'b1);
    set_config(OFFSET_W'(5), WAYS_W'(16));
    send_request(blk(101), blk(65), 1'b0);
  endtask

  // way count 0 and above the maximum, offsets from 0 up to their limit
  task automatic test_config_extremes();
    set_config(OFFSET_W'(0), WAYS_W'(0));
    send_request(32'hFFFF_FFFF, 32'h8000_0001, 1'b1);
    send_request(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
    set_config(OFFSET_W'(15), WAYS_W'(31));
    send_request(32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1);
    send_request(32'hFFFF_8000, 32'h0000_7FFF, 1'b0);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    set_config(OFFSET_W'(12), WAYS_W'(17));
    send_request(32'hABCD_E123, 32'hABCD_EFFF, 1'b1);
    send_request(32'hABCD_EFFF, 32'h0000_0FFF, 1'b0);
    set_config(OFFSET_W'(13), WAYS_W'(1));
    send_request(32'h0000_1FFF, 32'hFFFF_E000, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
  endtask

  // phases of random traffic across settings and sender idle rates
  task automatic test_random_traffic();
    logic [OFFSET_W-1:0] offsets [10] = '{4'd0, 4'd5, 4'd12, 4'd15, 4'd3,
                                          4'd13, 4'd8, 4'd1, 4'd5, 4'd14};
    logic [WAYS_W-1:0]   ways    [10] = '{5'd16, 5'd1, 5'd31, 5'd16, 5'd4,
                                          5'd0, 5'd17, 5'd8, 5'd2, 5'd16};
    int unsigned         idle_pct;
    logic [ADDR_W-1:0]   blk_addr;
    for (int p = 0; p < 10; p++) begin
      set_config(offsets[p], ways[p]);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 88;
        default: idle_pct = 27;
      endcase
      for (int k = 0; k < 125; k++) begin
        // most block addresses come back from earlier victims to make hits
        if (recent_victims.size() != 0 && $urandom_range(0, 99) < 55)
          blk_addr = recent_victims[$urandom_range(0, recent_victims.size() - 1)];
        else
          blk_addr = make_address();
        send_request(blk_addr, make_address(), 1'($urandom));
        // sender waits out every result now and then, always mid phase one
        if ((p == 1 && k == 60) || $urandom_range(0, 99) == 0)
          wait_drain();
        else
          idle_cycles(idle_pct);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_fill_and_hit();
    test_replacement();
    test_config_extremes();
    test_random_traffic();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("victim_cache_swap verification clean");
    end else begin
      $display("victim_cache_swap verification failed");
    end
    $finish;
  end

endmodule
